// File: sv/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// Used by mf3_median9, mf3_line_mem users and the top level; no dependencies.
package mf3_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;
  localparam int unsigned MinSize      = 3;
  localparam int unsigned PixW         = 8;
  localparam int unsigned CoordW       = 11;
  localparam int unsigned CfgW         = 12;
  localparam int unsigned WinSize      = 3;
  localparam int unsigned WinArea      = WinSize * WinSize;
  localparam int unsigned LineW        = 2 * PixW;

  localparam logic [CfgW-1:0] WidthRst  = 12'd640;
  localparam logic [CfgW-1:0] HeightRst = 12'd480;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } mf3_cfg_e;

  // Nine window pixels; entries 3k..3k+2 are one column, top to bottom.
  typedef logic [WinArea-1:0][PixW-1:0] mf3_win_t;

  typedef struct packed {
    logic              last;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } mf3_tag_t;

  function automatic logic [PixW-1:0] pix_min(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PixW-1:0] pix_max(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PixW-1:0] pix_med3(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b,
                                               input logic [PixW-1:0] c);
    return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
  endfunction

endpackage

// File: sv/mf3_line_mem.sv
// Line buffer memory: one write port, one read port, registered read data.
// Holds the two previous rows side by side in each word; no dependencies.
module mf3_line_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned DW    = 16
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]            rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/mf3_median9.sv
// Three-stage median-of-nine pipeline with valid/ready flow control.
// Depends on mf3_pkg for the window and tag types and compare helpers.
module mf3_median9
  import mf3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mf3_win_t        in_win_i,
  input  mf3_tag_t        in_tag_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] out_med_o,
  output mf3_tag_t        out_tag_o
);

  logic            a_v_q, b_v_q, o_v_q;
  logic            en_a, en_b, en_o;
  logic [PixW-1:0] lo_d [WinSize];
  logic [PixW-1:0] md_d [WinSize];
  logic [PixW-1:0] hi_d [WinSize];
  logic [PixW-1:0] lo_q [WinSize];
  logic [PixW-1:0] md_q [WinSize];
  logic [PixW-1:0] hi_q [WinSize];
  mf3_tag_t        a_tag_q, b_tag_q, o_tag_q;
  logic [PixW-1:0] b_lo_q, b_md_q, b_hi_q;
  logic [PixW-1:0] o_med_q;

  // A stage loads whenever it is empty or its content moves on.
  assign en_o       = !o_v_q || out_ready_i;
  assign en_b       = !b_v_q || en_o;
  assign en_a       = !a_v_q || en_b;
  assign in_ready_o = en_a;

  // First stage sorts each column of three.
  always_comb begin
    for (int k = 0; k < WinSize; k++) begin
      lo_d[k] = pix_min(pix_min(in_win_i[3*k], in_win_i[3*k+1]), in_win_i[3*k+2]);
      hi_d[k] = pix_max(pix_max(in_win_i[3*k], in_win_i[3*k+1]), in_win_i[3*k+2]);
      md_d[k] = pix_med3(in_win_i[3*k], in_win_i[3*k+1], in_win_i[3*k+2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= in_valid_i;
      if (en_b) b_v_q <= a_v_q;
      if (en_o) o_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      lo_q    <= lo_d;
      md_q    <= md_d;
      hi_q    <= hi_d;
      a_tag_q <= in_tag_i;
    end
    // Median of nine equals the median of: largest column minimum,
    // median of column medians, smallest column maximum.
    if (en_b && a_v_q) begin
      b_lo_q  <= pix_max(pix_max(lo_q[0], lo_q[1]), lo_q[2]);
      b_md_q  <= pix_med3(md_q[0], md_q[1], md_q[2]);
      b_hi_q  <= pix_min(pix_min(hi_q[0], hi_q[1]), hi_q[2]);
      b_tag_q <= a_tag_q;
    end
    if (en_o && b_v_q) begin
      o_med_q <= pix_med3(b_lo_q, b_md_q, b_hi_q);
      o_tag_q <= b_tag_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_med_o   = o_med_q;
  assign out_tag_o   = o_tag_q;

endmodule

// File: sv/median_filter_3x3_core.sv
// 3x3 median filter over a raster-order stream of 8-bit pixels.
// A result passes the stage-1 registers and the median pipeline on its way to the master side.
// Throughput: one pixel per cycle while the master side takes results, set by the single
// read and write-back of the line memory that each pixel makes.
// Reset clears counters, window and pipeline and sets size to 640 x 480; the line
// memory is not cleared, as the first two rows of a frame fill it before use.
module median_filter_3x3_core
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] pixel_value
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // [7:0] median_value, [18:8] center_row,
                                          // [29:19] center_col, [31:30] zero
  output logic            m_axis_tlast    // frame_last
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CfgW-1:0] width_q, height_q;
  logic [CW:0]     w_eff;
  logic [RW:0]     h_eff;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW:0]     col_inc;
  logic [RW:0]     row_inc;
  logic [CW-1:0]   col_m1;
  logic [RW-1:0]   row_m1;
  logic            accept;
  logic            adv1;
  logic            v1_q, emit1_q;
  logic [PixW-1:0] pix1_q;
  logic [CW-1:0]   addr1_q;
  mf3_tag_t        tag_d, tag1_q;
  logic [LineW-1:0] rd_data;
  logic [PixW-1:0] top_pix, mid_pix;
  logic            wr_en;
  logic [PixW-1:0] win_q [6];
  mf3_win_t        win;
  logic            med_in_ready;
  logic            med_valid;
  logic [PixW-1:0] med_value;
  mf3_tag_t        med_tag;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_valid_i) begin
      unique case (mf3_cfg_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes saturate into [3, MAX].
  always_comb begin
    if (width_q < CfgW'(MinSize)) w_eff = (CW+1)'(MinSize);
    else if (32'(width_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width_q);
    if (height_q < CfgW'(MinSize)) h_eff = (RW+1)'(MinSize);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(height_q);
  end

  // Stage 0: accept a pixel, start the line memory read, move the counters.
  assign adv1          = !emit1_q || med_in_ready;
  assign s_axis_tready = !v1_q || adv1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
    col_m1     = col_q - 1'b1;
    row_m1     = row_q - 1'b1;
    tag_d.row  = CoordW'(row_m1);
    tag_d.col  = CoordW'(col_m1);
    tag_d.last = ({1'b0, col_q} == w_eff - 1'b1) && ({1'b0, row_q} == h_eff - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s_axis_tready) v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit1_q <= 1'b0;
    end else if (accept) begin
      emit1_q <= (col_q >= CW'(2)) && (row_q >= RW'(2));
    end else if (s_axis_tready) begin
      emit1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= s_axis_tdata[PixW-1:0];
      addr1_q <= col_q;
      tag1_q  <= tag_d;
    end
  end

  // Stage 1: line data is back; write the column down one row and shift the
  // window. Consecutive pixels never share a column, so no forwarding is needed.
  mf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (LineW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr1_q),
    .wr_data_i ({pix1_q, mid_pix})
  );

  assign top_pix = rd_data[PixW-1:0];
  assign mid_pix = rd_data[LineW-1:PixW];
  assign wr_en   = v1_q && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (wr_en) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_pix;
      win_q[4] <= mid_pix;
      win_q[5] <= pix1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) win[i] = win_q[i];
    win[6] = top_pix;
    win[7] = mid_pix;
    win[8] = pix1_q;
  end

  assign med_valid = v1_q && emit1_q;

  mf3_median9 u_median9 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (med_valid),
    .in_ready_o  (med_in_ready),
    .in_win_i    (win),
    .in_tag_i    (tag1_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_med_o   (med_value),
    .out_tag_o   (med_tag)
  );

  assign m_axis_tdata = {2'b00, med_tag.col, med_tag.row, med_value};
  assign m_axis_tlast = med_tag.last;

endmodule

// File: sv/mf3_checker.sv
// Port-level checks for median_filter_3x3_core, attached by bind.
// Depends on the top level's port list only.
module mf3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic after_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      after_last_q <= m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Reset clears the valid flag asynchronously, so it stays low while reset is held.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:8] != 11'd0 && m_axis_tdata[29:19] != 11'd0 &&
      m_axis_tdata[31:30] == 2'b00)
    else $error("result centre lies on the border");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && after_last_q |->
      m_axis_tdata[18:8] == 11'd1 && m_axis_tdata[29:19] == 11'd1)
    else $error("first result of a frame is not at row 1, column 1");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the result side is free");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for median_filter_3x3_core: streams pixel frames, predicts medians.
// Depends on mf3_pkg and the core; holds a small scoreboard class with its own filter model.
module tb_top;
  import mf3_pkg::*;

  localparam int unsigned RandomPixels = 460;
  localparam int unsigned CalmPixels   = 100;
  localparam int unsigned FillWidth    = 40;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned QuietLimit   = 1000;

  typedef struct packed {
    logic [PixW-1:0]   median;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              last;
  } median_result_t;

  class median_scoreboard;
    logic [PixW-1:0] line_two_up [MaxWidthDef];
    logic [PixW-1:0] line_one_up [MaxWidthDef];
    // Entries 0..2 hold the older column, 3..5 the newer one, each top to bottom.
    logic [PixW-1:0] win_cols [6];
    int unsigned     col_pos;
    int unsigned     row_pos;
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    median_result_t  awaited [$];
    int unsigned     errors;

    function new();
      foreach (line_two_up[i]) line_two_up[i] = '0;
      foreach (line_one_up[i]) line_one_up[i] = '0;
      foreach (win_cols[i]) win_cols[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = WidthRst;
      height_reg = HeightRst;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void set_register(mf3_cfg_e idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_WIDTH:  width_reg = val;
        CFG_HEIGHT: height_reg = val;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [CfgW-1:0] v, int unsigned top);
      if (v < MinSize) return MinSize;
      if (v > top) return top;
      return v;
    endfunction

    // The median is the value with at most four entries below it and at least five at or below.
    function logic [PixW-1:0] mid_of_nine(logic [WinArea-1:0][PixW-1:0] v);
      int below;
      int not_above;
      for (int i = 0; i < WinArea; i++) begin
        below     = 0;
        not_above = 0;
        for (int j = 0; j < WinArea; j++) begin
          if (v[j] < v[i]) below++;
          if (v[j] <= v[i]) not_above++;
        end
        if (below <= WinArea / 2 && not_above > WinArea / 2) return v[i];
      end
      return '0;
    endfunction

    function void note_pixel(logic [PixW-1:0] pix);
      int unsigned                 w;
      int unsigned                 h;
      int unsigned                 slot;
      logic [PixW-1:0]             up2;
      logic [PixW-1:0]             up1;
      logic [WinArea-1:0][PixW-1:0] nine;
      median_result_t              res;
      w    = clamp_dim(width_reg, MaxWidthDef);
      h    = clamp_dim(height_reg, MaxHeightDef);
      slot = col_pos % MaxWidthDef;
      up2  = line_two_up[slot];
      up1  = line_one_up[slot];
      if (row_pos >= 2 && col_pos >= 2) begin
        nine       = {win_cols[0], win_cols[1], win_cols[2], win_cols[3], win_cols[4],
                      win_cols[5], up2, up1, pix};
        res.median = mid_of_nine(nine);
        res.row    = CoordW'(row_pos - 1);
        res.col    = CoordW'(col_pos - 1);
        res.last   = (row_pos == h - 1) && (col_pos == w - 1);
        awaited.push_back(res);
      end
      line_two_up[slot] = up1;
      line_one_up[slot] = pix;
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = up2;
      win_cols[4] = up1;
      win_cols[5] = pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] data, logic last_flag);
      median_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result beat %h with nothing expected", data));
        return;
      end
      want = awaited.pop_front();
      if (data[PixW-1:0] !== want.median)
        flag_mismatch($sformatf("median_value %0d, expected %0d at (%0d,%0d)",
                                data[PixW-1:0], want.median, want.row, want.col));
      if (data[PixW+CoordW-1:PixW] !== want.row)
        flag_mismatch($sformatf("center_row %0d, expected %0d",
                                data[PixW+CoordW-1:PixW], want.row));
      if (data[PixW+2*CoordW-1:PixW+CoordW] !== want.col)
        flag_mismatch($sformatf("center_col %0d, expected %0d",
                                data[PixW+2*CoordW-1:PixW+CoordW], want.col));
      if (last_flag !== want.last)
        flag_mismatch($sformatf("frame_last %b, expected %b at (%0d,%0d)",
                                last_flag, want.last, want.row, want.col));
    endtask

    task flush_leftovers();
      if (awaited.size() != 0)
        flag_mismatch($sformatf("%0d expected results never arrived", awaited.size()));
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;    // [7:0] pixel_value
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;         // [7:0] median, [18:8] row, [29:19] col
  logic            m_axis_tlast;

  median_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      gap_odds = 0;
  logic [PixW-1:0]  shade = '0;
  int unsigned      quiet_cycles = 0;

  median_filter_3x3_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : sink_pacing
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] pix);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(pix);
  endtask

  // Leaves cfg_valid_i high so that a second write can follow in the next cycle.
  task automatic write_register(input mf3_cfg_e idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, val);
  endtask

  task automatic reconfigure(input bit do_w, input logic [CfgW-1:0] w,
                             input bit do_h, input logic [CfgW-1:0] h);
    if (do_w) write_register(CFG_WIDTH, w);
    if (do_h) write_register(CFG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  // Border pixels produce nothing, so the pipeline may still hold work after the last result.
  task automatic idle_until_done();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2, 3, 4: return shade + PixW'($urandom_range(0, 3));
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // Oversized values saturate to the maximum. Only heights get them, since a row that wide
  // would reach line-memory columns that were never filled.
  function automatic logic [CfgW-1:0] pick_size(input bit allow_big);
    case ($urandom_range(0, 19))
      0:       return CfgW'($urandom_range(0, 2));
      1:       return allow_big ? CfgW'($urandom_range(2049, 4095)) : CfgW'(FillWidth);
      2, 3:    return CfgW'($urandom_range(11, FillWidth));
      default: return CfgW'($urandom_range(3, 10));
    endcase
  endfunction

  initial begin : stimulus
    logic [WinArea-1:0][PixW-1:0] cross_pattern;
    int unsigned                  sent;
    int unsigned                  run_len;
    int unsigned                  mask;
    cross_pattern = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes below the minimum saturate to 3 x 3: one interior pixel, which ends the frame.
    gap_odds = 3;
    reconfigure(1'b1, 12'd0, 1'b1, 12'd2);
    for (int i = 0; i < WinArea; i++) send_pixel(cross_pattern[i]);
    repeat (WinArea) send_pixel(8'hFF);
    idle_until_done();

    // One frame at the widest width used below fills every line-memory column that later
    // frames can reach; after it a width change in the middle of a frame never reads an
    // unwritten entry.
    reconfigure(1'b1, CfgW'(FillWidth), 1'b1, 12'd3);
    shade = 8'd100;
    repeat (FillWidth * 3) send_pixel(random_pixel());
    idle_until_done();

    // Short phases with fresh sizes; most changes land in the middle of a frame.
    sent = 0;
    while (sent < RandomPixels) begin
      mask = $urandom_range(1, 3);
      reconfigure(mask[0], pick_size(1'b0), mask[1], pick_size(1'b1));
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      shade    = PixW'($urandom_range(0, 252));
      run_len  = $urandom_range(8, 60);
      repeat (run_len) begin
        calm = (sent >= RandomPixels - CalmPixels);
        send_pixel(random_pixel());
        sent++;
      end
      idle_until_done();
    end

    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mf3_pkg.sv
sv/mf3_line_mem.sv
sv/mf3_median9.sv
sv/median_filter_3x3_core.sv
sv/mf3_checker.sv
sim/tb_top.sv
